// ===== sv/mrbr_pkg.sv =====
// shared types, widths and key compare for the monotonic run bucket router
package mrbr_pkg;

  localparam int DEF_NUM_BUCKETS = 16;
  localparam int TOKEN_W         = 64;
  localparam int RANK_W          = 32;
  localparam int MAXB_W          = 5;
  localparam int BUCKET_W        = 4;
  localparam int SLOT_W          = 6;
  localparam int COUNT_W         = SLOT_W + 1;
  localparam logic [MAXB_W-1:0] MAXB_RESET = 5'd16;

  typedef logic [TOKEN_W-1:0] token_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic   valid;
    logic   cur_fit;
    logic   found;
    token_t gap;
    slot_t  best;
    logic   max_valid;
    token_t max_tok;
    rank_t  max_rank;
    slot_t  max_slot;
  } scan_pkt_t;

  // key broadcast and write port from the controller to every cell
  typedef struct packed {
    token_t tok;
    rank_t  rank;
    slot_t  cur;
    count_t count;
    logic   wr_en;
    slot_t  wr_slot;
  } cell_ctl_t;

  // key (ta,ra) strictly below key (tb,rb): signed token, then unsigned rank
  function automatic logic key_less(token_t ta, rank_t ra, token_t tb, rank_t rb);
    logic lt;
    lt = ($signed(ta) < $signed(tb)) || ((ta == tb) && (ra < rb));
    return lt;
  endfunction

endpackage

// ===== sv/mrbr_cell.sv =====
// one bucket cell: last key storage plus one step of the bucket search
module mrbr_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mrbr_pkg::cell_ctl_t   ctl,
  input  mrbr_pkg::scan_pkt_t   pkt_in,
  output mrbr_pkg::scan_pkt_t   pkt_out
);
  import mrbr_pkg::*;

  localparam slot_t  MY_SLOT  = slot_t'(INDEX);
  localparam count_t MY_COUNT = count_t'(INDEX);

  token_t    last_tok;
  rank_t     last_rank;
  scan_pkt_t pkt_next;
  logic      active;
  logic      below;
  logic      take_best;
  logic      take_max;
  token_t    gap;

  always_comb begin
    active    = ctl.count > MY_COUNT;
    below     = key_less(last_tok, last_rank, ctl.tok, ctl.rank);
    gap       = ctl.tok - last_tok;
    take_best = active && below && (!pkt_in.found || (gap < pkt_in.gap));
    take_max  = active && (!pkt_in.max_valid ||
                key_less(pkt_in.max_tok, pkt_in.max_rank, last_tok, last_rank));
    pkt_next  = pkt_in;
    if ((ctl.cur == MY_SLOT) && below) begin
      pkt_next.cur_fit = 1'b1;
    end
    if (take_best) begin
      pkt_next.found = 1'b1;
      pkt_next.gap   = gap;
      pkt_next.best  = MY_SLOT;
    end
    if (take_max) begin
      pkt_next.max_valid = 1'b1;
      pkt_next.max_tok   = last_tok;
      pkt_next.max_rank  = last_rank;
      pkt_next.max_slot  = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_slot == MY_SLOT)) begin
      last_tok  <= ctl.tok;
      last_rank <= ctl.rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out <= '0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

// ===== sv/monotonic_run_bucket_router.sv =====
// top level: controller and chain of bucket cells
//
// A partition start (cmd 0) sets a launch register on acceptance; the search state then
// walks the row of bucket cells one cell per cycle, and the bucket choice and key write
// happen in the cycle after the walk leaves the last cell. busy stays high over that walk
// and drops in the cycle the result strobe rises, so the next transaction may be taken
// while the result is shown. Any other fragment (cmd 1) gives its result in the cycle
// after acceptance and keeps busy low. done marks a result for exactly one cycle and
// cannot be held off by the receiver. The user must write the bucket limit through
// cfg_wr_en / cfg_wr_data while no transaction is in flight; the block does not enforce
// this. Values of 0 act as 1 and values above NUM_BUCKETS act as NUM_BUCKETS.
module monotonic_run_bucket_router #(
  parameter int NUM_BUCKETS = mrbr_pkg::DEF_NUM_BUCKETS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cmd,
  input  logic signed [mrbr_pkg::TOKEN_W-1:0]   token,
  input  logic [mrbr_pkg::RANK_W-1:0]           key_rank,
  input  logic                                  cfg_wr_en,
  input  logic [mrbr_pkg::MAXB_W-1:0]           cfg_wr_data,
  output logic                                  done,
  output logic [mrbr_pkg::BUCKET_W-1:0]         bucket,
  output logic                                  opened,
  output logic                                  replaced,
  output logic                                  no_bucket
);
  import mrbr_pkg::*;

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
  localparam int CMP_W = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;
  localparam logic [CMP_W-1:0] NUM_CMP = CMP_W'(NUM_BUCKETS);
  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t              state;
  logic [MAXB_W-1:0]   bucket_limit;
  logic [CNT_W-1:0]    open_count;
  logic [IDX_W-1:0]    cur;
  logic                have_current;
  logic                launch;
  token_t              key_tok;
  rank_t               key_rk;

  cell_ctl_t           ctl;
  scan_pkt_t           chain_pkt [NUM_BUCKETS+1];
  scan_pkt_t           tail;

  logic [CMP_W-1:0]    mb_ext;
  logic [CMP_W-1:0]    eff_max;
  logic                can_open;
  logic                place_new;
  logic                decide;
  logic [IDX_W-1:0]    dest;
  logic [IDX_W+BUCKET_W-1:0] dest_wide;
  logic [IDX_W+BUCKET_W-1:0] cur_wide;

  assign busy = (state != IDLE);

  always_comb begin
    chain_pkt[0]       = '0;
    chain_pkt[0].valid = launch;
  end

  for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
    mrbr_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .pkt_in (chain_pkt[i]),
      .pkt_out(chain_pkt[i+1])
    );
  end

  assign tail = chain_pkt[NUM_BUCKETS];

  always_comb begin
    mb_ext = CMP_W'(bucket_limit);
    if (mb_ext == '0) begin
      eff_max = ONE_CMP;
    end else if (mb_ext > NUM_CMP) begin
      eff_max = NUM_CMP;
    end else begin
      eff_max = mb_ext;
    end
    can_open  = CMP_W'(open_count) < eff_max;
    decide    = (state == SCAN) && tail.valid;
    place_new = 1'b0;
    if (!have_current || (open_count == '0)) begin
      place_new = 1'b1;
      dest      = can_open ? open_count[IDX_W-1:0] : tail.max_slot[IDX_W-1:0];
    end else if (tail.cur_fit) begin
      dest      = cur;
    end else if (tail.found) begin
      dest      = tail.best[IDX_W-1:0];
    end else begin
      place_new = 1'b1;
      dest      = can_open ? open_count[IDX_W-1:0] : tail.max_slot[IDX_W-1:0];
    end
    dest_wide = {{BUCKET_W{1'b0}}, dest};
    cur_wide  = {{BUCKET_W{1'b0}}, cur};

    ctl.tok     = key_tok;
    ctl.rank    = key_rk;
    ctl.cur     = slot_t'(cur);
    ctl.count   = count_t'(open_count);
    ctl.wr_en   = decide;
    ctl.wr_slot = slot_t'(dest);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      bucket_limit <= MAXB_RESET;
      open_count   <= '0;
      cur          <= '0;
      have_current <= 1'b0;
      launch       <= 1'b0;
      done         <= 1'b0;
      bucket       <= '0;
      opened       <= 1'b0;
      replaced     <= 1'b0;
      no_bucket    <= 1'b0;
    end else begin
      done   <= 1'b0;
      launch <= 1'b0;
      if (cfg_wr_en) begin
        bucket_limit <= cfg_wr_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            if (cmd) begin
              done      <= 1'b1;
              bucket    <= have_current ? cur_wide[BUCKET_W-1:0] : '0;
              opened    <= 1'b0;
              replaced  <= 1'b0;
              no_bucket <= !have_current;
            end else begin
              key_tok <= token;
              key_rk  <= key_rank;
              launch  <= 1'b1;
              state   <= SCAN;
            end
          end
        end
        SCAN: begin
          if (tail.valid) begin
            done         <= 1'b1;
            bucket       <= dest_wide[BUCKET_W-1:0];
            opened       <= place_new && can_open;
            replaced     <= place_new && !can_open;
            no_bucket    <= 1'b0;
            cur          <= dest;
            have_current <= 1'b1;
            if (place_new && can_open) begin
              open_count <= open_count + CNT_W'(1);
            end
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/mrbr_checker.sv =====
// port level checks for the monotonic run bucket router, bound to the top level
module mrbr_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  cmd,
  input logic                                  done,
  input logic [mrbr_pkg::BUCKET_W-1:0]         bucket,
  input logic                                  opened,
  input logic                                  replaced,
  input logic                                  no_bucket
);

  // a result only follows an accepted transaction or a running search
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a transaction");

  // a partition start always enters the search
  a_start_search: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cmd) |=> (busy && !done))
    else $error("partition start did not begin a search");

  // a fragment answers in the next cycle
  a_frag_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> (done && !opened && !replaced))
    else $error("fragment result missing or flagged");

  // flags are exclusive and an orphan fragment points at bucket zero
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> (!(opened && replaced) &&
              (!no_bucket || (!opened && !replaced && bucket == '0))))
    else $error("inconsistent result flags");

endmodule

bind monotonic_run_bucket_router mrbr_checker u_mrbr_checker (.*);
